>>> src/cpsp_pkg.sv
// Shared types and constants for the cascaded position/speed PID core.
package cpsp_pkg;

  localparam int unsigned INTEGRAL_WIDTH_DEF = 40;

  localparam int unsigned DATA_W    = 32;  // Q16.16 samples
  localparam int unsigned ERR_W     = 33;  // exact difference of two samples
  localparam int unsigned GAIN_W    = 16;  // unsigned Q8.8 gains
  localparam int unsigned LIMIT_W   = 31;  // unsigned Q15.16 clamps
  localparam int unsigned OP_W      = 34;  // multiplier data operand
  localparam int unsigned PROD_W    = GAIN_W + 1 + OP_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned HI_SHIFT  = 32;  // weight of the upper integral chunk

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_KP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_KI    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_KD    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_LIMIT = 3'd7;

  typedef struct packed {
    logic [GAIN_W-1:0]  pos_kp;
    logic [GAIN_W-1:0]  pos_ki;
    logic [GAIN_W-1:0]  pos_kd;
    logic [LIMIT_W-1:0] pos_limit;
    logic [GAIN_W-1:0]  spd_kp;
    logic [GAIN_W-1:0]  spd_ki;
    logic [GAIN_W-1:0]  spd_kd;
    logic [LIMIT_W-1:0] spd_limit;
  } cfg_t;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clr;       // zero the accumulator
    logic issue;     // start a product this cycle
    logic shift_hi;  // product belongs to the upper integral chunk
  } mac_ctrl_t;

endpackage

>>> src/cpsp_cfg.sv
// Configuration register file of the PID core.
module cpsp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpsp_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  output cpsp_pkg::cfg_t                 cfg_o
);

  cpsp_pkg::cfg_t cfg_q;
  logic [cpsp_pkg::GAIN_W-1:0] gain_d;

  assign gain_d = cfg_wdata_i[cpsp_pkg::GAIN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpsp_pkg::CFG_POS_KP:    cfg_q.pos_kp    <= gain_d;
        cpsp_pkg::CFG_POS_KI:    cfg_q.pos_ki    <= gain_d;
        cpsp_pkg::CFG_POS_KD:    cfg_q.pos_kd    <= gain_d;
        cpsp_pkg::CFG_POS_LIMIT: cfg_q.pos_limit <= cfg_wdata_i;
        cpsp_pkg::CFG_SPD_KP:    cfg_q.spd_kp    <= gain_d;
        cpsp_pkg::CFG_SPD_KI:    cfg_q.spd_ki    <= gain_d;
        cpsp_pkg::CFG_SPD_KD:    cfg_q.spd_kd    <= gain_d;
        cpsp_pkg::CFG_SPD_LIMIT: cfg_q.spd_limit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/cpsp_mac.sv
// Shared gain multiplier with registered product and wide accumulator.
module cpsp_mac #(
  parameter int unsigned INTEGRAL_WIDTH = cpsp_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cpsp_pkg::mac_ctrl_t              ctrl_i,
  input  logic [cpsp_pkg::GAIN_W-1:0]      gain_i,
  input  logic signed [cpsp_pkg::OP_W-1:0] op_i,
  output logic signed [INTEGRAL_WIDTH+18:0] acc_o
);

  localparam int unsigned ACC_W  = INTEGRAL_WIDTH + 19;
  localparam int unsigned PROD_W = cpsp_pkg::PROD_W;

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic                     pvld_q;
  logic                     psh_q;
  logic signed [ACC_W-1:0]  addend_d;
  logic signed [ACC_W-1:0]  acc_q;

  assign prod_d = $signed({1'b0, gain_i}) * op_i;

  always_comb begin
    addend_d = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (psh_q) begin
      addend_d = addend_d <<< cpsp_pkg::HI_SHIFT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      pvld_q <= ctrl_i.issue;
      if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (pvld_q) begin
        acc_q <= acc_q + addend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= prod_d;
      psh_q  <= ctrl_i.shift_hi;
    end
  end

  assign acc_o = acc_q;

  // a clear never collides with a pending product
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.clr |-> !pvld_q)
    else $error("accumulator clear while product pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.clr |=> acc_q == '0)
    else $error("accumulator not zero after clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!ctrl_i.clr && !pvld_q) |=> $stable(acc_q))
    else $error("accumulator moved without a product");

endmodule

>>> src/cascaded_position_speed_pid_core.sv
// Top level of the cascaded position/speed PID servo core.
// Usage:
//   One transaction on the s_axis side is one control tick. tuser selects the
//   mode: 0 runs the speed loop alone on target, 1 first runs the position
//   loop on target - angle_fdb and feeds its clamped output to the speed loop.
//   Each tick yields one transaction on the m_axis side carrying the clamped
//   drive value and the speed reference used. Gains and limits are written on
//   the cfg port while no tick is in flight.
// Sequencing:
//   A single 17x34 multiplier is shared by all products under a small
//   sequencer; four products per loop, one issued per cycle.
//   s_axis_tready is high only while the sequencer waits for a tick.
// Reset:
//   Gains, limits, integral, error history and the accumulated output all
//   clear to zero; no result is pending.
// Stall:
//   The result sits in an output register, so a new tick is taken while the
//   receiver stalls; a second result waits in the last step until it drains.
module cascaded_position_speed_pid_core #(
  parameter int unsigned INTEGRAL_WIDTH = cpsp_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side: tdata = {speed_fdb, angle_fdb, target}, highest first
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [95:0]                    s_axis_tdata,   // target, angle_fdb, speed_fdb
  input  logic                           s_axis_tuser,   // func
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [63:0]                    m_axis_tdata,   // drive, speed_ref
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [cpsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpsp_pkg::LIMIT_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IW    = INTEGRAL_WIDTH;
  localparam int unsigned ACC_W = IW + 19;      // exact sum of the four products of a loop
  localparam int unsigned SH_W  = ACC_W - 8;    // sum after the Q8.8 shift
  localparam int unsigned CW    = ACC_W - 7;    // clamp input, one guard bit
  localparam int unsigned DW    = cpsp_pkg::DATA_W;
  localparam int unsigned EW    = cpsp_pkg::ERR_W;
  localparam int unsigned OW    = cpsp_pkg::OP_W;
  localparam int unsigned LW    = cpsp_pkg::LIMIT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PERR, ST_PMUL, ST_PDRAIN, ST_PCLAMP,
    ST_SERR, ST_SMUL, ST_SDRAIN, ST_SOUT
  } state_e;

  cpsp_pkg::cfg_t      cfg;
  cpsp_pkg::mac_ctrl_t mac_ctrl;

  state_e state_q;
  logic [1:0] mul_idx_q;
  logic       m_valid_q;

  // loop state
  logic signed [IW-1:0] int_q;
  logic signed [EW-1:0] pos_last_q;
  logic signed [EW-1:0] spd_last_q;
  logic signed [EW-1:0] spd_before_q;
  logic signed [DW-1:0] out_acc_q;

  // per-tick working registers
  logic signed [DW-1:0] target_q, angle_q, speed_q, sref_q;
  logic signed [EW-1:0] err_q;
  logic signed [OW-1:0] dif_q, dif2_q;
  logic [63:0]          m_data_q;

  logic in_fire, out_free;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  cpsp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // error terms
  logic signed [EW-1:0] perr_d, serr_d;
  logic signed [IW:0]   int_sum;
  logic signed [IW-1:0] int_d;
  logic signed [OW-1:0] pdif_d, sdif_d, sdif2_d;

  assign perr_d  = {target_q[DW-1], target_q} - {angle_q[DW-1], angle_q};
  assign serr_d  = {sref_q[DW-1], sref_q} - {speed_q[DW-1], speed_q};
  assign pdif_d  = {perr_d[EW-1], perr_d} - {pos_last_q[EW-1], pos_last_q};
  assign sdif_d  = {serr_d[EW-1], serr_d} - {spd_last_q[EW-1], spd_last_q};
  assign sdif2_d = {spd_before_q[EW-1], spd_before_q} - {spd_last_q[EW-1], spd_last_q};

  // integral saturates at the signed IW-bit range
  assign int_sum = {int_q[IW-1], int_q} + {{(IW+1-EW){perr_d[EW-1]}}, perr_d};
  always_comb begin
    int_d = int_sum[IW-1:0];
    if (int_sum[IW] != int_sum[IW-1]) begin
      int_d = int_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end
  end

  // operand select for the shared multiplier
  logic [cpsp_pkg::GAIN_W-1:0] mac_gain;
  logic signed [OW-1:0]        mac_op;
  logic signed [ACC_W-1:0]     acc;

  always_comb begin
    mac_ctrl          = '0;
    mac_ctrl.clr      = (state_q == ST_PERR) || (state_q == ST_SERR);
    mac_ctrl.issue    = (state_q == ST_PMUL) || (state_q == ST_SMUL);
    mac_gain          = cfg.spd_kd;
    mac_op            = dif2_q;
    if (state_q == ST_PMUL) begin
      case (mul_idx_q)
        2'd0: begin
          mac_gain = cfg.pos_kp;
          mac_op   = {err_q[EW-1], err_q};
        end
        2'd1: begin
          // lower integral chunk, unsigned
          mac_gain = cfg.pos_ki;
          mac_op   = {{(OW-32){1'b0}}, int_q[31:0]};
        end
        2'd2: begin
          // upper integral chunk, signed, weighted by 2^32
          mac_gain          = cfg.pos_ki;
          mac_op            = {{(OW-(IW-32)){int_q[IW-1]}}, int_q[IW-1:32]};
          mac_ctrl.shift_hi = 1'b1;
        end
        default: begin
          mac_gain = cfg.pos_kd;
          mac_op   = dif_q;
        end
      endcase
    end else begin
      case (mul_idx_q)
        2'd0: begin
          mac_gain = cfg.spd_kp;
          mac_op   = dif_q;
        end
        2'd1: begin
          mac_gain = cfg.spd_ki;
          mac_op   = {err_q[EW-1], err_q};
        end
        2'd2: begin
          mac_gain = cfg.spd_kd;
          mac_op   = dif_q;
        end
        default: begin
          // kd * (e - 2 last + before) split as kd*(e-last) + kd*(before-last)
          mac_gain = cfg.spd_kd;
          mac_op   = dif2_q;
        end
      endcase
    end
  end

  cpsp_mac #(
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mac_ctrl),
    .gain_i(mac_gain),
    .op_i  (mac_op),
    .acc_o (acc)
  );

  // shared clamp: floor shift by 8, optional add of the held output, +-limit
  logic signed [SH_W-1:0] shr_d;
  logic signed [CW-1:0]   cl_in, cl_lim, cl_out;

  assign shr_d = acc[ACC_W-1:8];

  always_comb begin
    if (state_q == ST_SOUT) begin
      cl_in  = {{(CW-DW){out_acc_q[DW-1]}}, out_acc_q} + {shr_d[SH_W-1], shr_d};
      cl_lim = {{(CW-LW){1'b0}}, cfg.spd_limit};
    end else begin
      cl_in  = {shr_d[SH_W-1], shr_d};
      cl_lim = {{(CW-LW){1'b0}}, cfg.pos_limit};
    end
    cl_out = cl_in;
    if (cl_in > cl_lim) begin
      cl_out = cl_lim;
    end else if (cl_in < -cl_lim) begin
      cl_out = -cl_lim;
    end
  end

  // sequencer, loop state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mul_idx_q    <= '0;
      m_valid_q    <= 1'b0;
      int_q        <= '0;
      pos_last_q   <= '0;
      spd_last_q   <= '0;
      spd_before_q <= '0;
      out_acc_q    <= '0;
    end else begin
      // the last step reloads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != ST_SOUT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= s_axis_tuser ? ST_PERR : ST_SERR;
          end
        end
        ST_PERR: begin
          int_q      <= int_d;
          pos_last_q <= perr_d;
          state_q    <= ST_PMUL;
        end
        ST_PMUL: begin
          mul_idx_q <= mul_idx_q + 2'd1;
          if (mul_idx_q == 2'd3) begin
            state_q <= ST_PDRAIN;
          end
        end
        ST_PDRAIN: state_q <= ST_PCLAMP;
        ST_PCLAMP: state_q <= ST_SERR;
        ST_SERR: begin
          spd_before_q <= spd_last_q;
          spd_last_q   <= serr_d;
          state_q      <= ST_SMUL;
        end
        ST_SMUL: begin
          mul_idx_q <= mul_idx_q + 2'd1;
          if (mul_idx_q == 2'd3) begin
            state_q <= ST_SDRAIN;
          end
        end
        ST_SDRAIN: state_q <= ST_SOUT;
        ST_SOUT: begin
          if (out_free) begin
            out_acc_q <= cl_out[DW-1:0];
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      target_q <= s_axis_tdata[31:0];
      angle_q  <= s_axis_tdata[63:32];
      speed_q  <= s_axis_tdata[95:64];
      sref_q   <= s_axis_tdata[31:0];  // speed mode uses target directly
    end
    if (state_q == ST_PERR) begin
      err_q <= perr_d;
      dif_q <= pdif_d;
    end
    if (state_q == ST_PCLAMP) begin
      sref_q <= cl_out[DW-1:0];
    end
    if (state_q == ST_SERR) begin
      err_q  <= serr_d;
      dif_q  <= sdif_d;
      dif2_q <= sdif2_d;
    end
    if ((state_q == ST_SOUT) && out_free) begin
      m_data_q <= {sref_q, cl_out[DW-1:0]};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> !s_axis_tready)
    else $error("second tick taken while one is in flight");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q != ST_PMUL && state_q != ST_SMUL) |-> mul_idx_q == 2'd0)
    else $error("product counter left running outside a multiply phase");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_SOUT && out_free) |=> (m_valid_q && state_q == ST_IDLE))
    else $error("result not presented after final step");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the cascaded position/speed PID servo core.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned IW          = cpsp_pkg::INTEGRAL_WIDTH_DEF;
  localparam int          CYCLE_LIMIT = 400000;  // far above the slowest legal run
  localparam int          TAIL_CYCLES = 20;      // longer than the position-mode latency
  localparam int          HOLD_LEN    = 250;     // receiver hold-off for the pressure test
  localparam bit          MODE_SPEED    = 1'b0;
  localparam bit          MODE_POSITION = 1'b1;
  localparam int          Q_MAX = 32'sh7FFF_FFFF;
  localparam int          Q_MIN = 32'sh8000_0000;

  // one control tick as it crosses the slave side
  typedef struct {
    bit                 func;
    logic signed [31:0] target;
    logic signed [31:0] angle_fdb;
    logic signed [31:0] speed_fdb;
  } tick_t;

  // one servo result as it crosses the master side
  typedef struct {
    logic signed [31:0] drive;
    logic signed [31:0] speed_ref;
  } servo_out_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [95:0]                    s_axis_tdata  = '0;  // target, angle_fdb, speed_fdb
  logic                           s_axis_tuser  = 1'b0;  // func
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [63:0]                    m_axis_tdata;  // drive, speed_ref
  logic                           cfg_we_i      = 1'b0;
  logic [cpsp_pkg::CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [cpsp_pkg::LIMIT_W-1:0]   cfg_wdata_i   = '0;

  // traffic shaping, percent of cycles spent idle on each side
  int src_idle_pct = 37;
  int snk_idle_pct = 82;
  int hold_cycles  = 0;

  // run statistics
  int errors          = 0;
  int speed_ticks     = 0;
  int position_ticks  = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int settings_count  = 0;
  int cycle_count     = 0;

  cascaded_position_speed_pid_core #(
    .INTEGRAL_WIDTH(IW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Servo predictor: own copy of gains, limits and loop state.
  // ---------------------------------------------------------------------------
  cpsp_pkg::cfg_t servo_cfg      = '0;
  longint         angle_sum      = 0;  // saturating position integral
  longint         angle_err_prev = 0;
  longint         spd_err_prev   = 0;
  longint         spd_err_prev2  = 0;
  longint         drive_acc      = 0;  // accumulated speed loop output

  // expected results, oldest first
  servo_out_t expected_servo_q[$];

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // gains keep their low 16 bits; limits use the whole 31-bit write
  function automatic void apply_reg(logic [cpsp_pkg::CFG_IDX_W-1:0] idx,
                                    logic [cpsp_pkg::LIMIT_W-1:0] val);
    case (idx)
      cpsp_pkg::CFG_POS_KP:    servo_cfg.pos_kp    = val[cpsp_pkg::GAIN_W-1:0];
      cpsp_pkg::CFG_POS_KI:    servo_cfg.pos_ki    = val[cpsp_pkg::GAIN_W-1:0];
      cpsp_pkg::CFG_POS_KD:    servo_cfg.pos_kd    = val[cpsp_pkg::GAIN_W-1:0];
      cpsp_pkg::CFG_POS_LIMIT: servo_cfg.pos_limit = val;
      cpsp_pkg::CFG_SPD_KP:    servo_cfg.spd_kp    = val[cpsp_pkg::GAIN_W-1:0];
      cpsp_pkg::CFG_SPD_KI:    servo_cfg.spd_ki    = val[cpsp_pkg::GAIN_W-1:0];
      cpsp_pkg::CFG_SPD_KD:    servo_cfg.spd_kd    = val[cpsp_pkg::GAIN_W-1:0];
      cpsp_pkg::CFG_SPD_LIMIT: servo_cfg.spd_limit = val;
      default: ;
    endcase
  endfunction

  // One control tick. Products are Q24.24, the sum is floored back to Q16.16.
  function automatic servo_out_t servo_tick(tick_t t);
    longint     err;
    longint     sum;
    longint     sref;
    longint     hi;
    longint     lo;
    longint     ki;
    longint     mag;
    longint     ki_term;
    servo_out_t r;
    sref = t.target;
    if (t.func == MODE_POSITION) begin
      err = longint'(t.target) - longint'(t.angle_fdb);
      hi  = (longint'(1) <<< (IW - 1)) - 1;
      lo  = -hi - 1;
      if (err > 0 && angle_sum > hi - err) angle_sum = hi;
      else if (err < 0 && angle_sum < lo - err) angle_sum = lo;
      else angle_sum = angle_sum + err;
      // integral product capped at 2^60 in magnitude
      ki  = longint'(servo_cfg.pos_ki);
      mag = (angle_sum < 0) ? -angle_sum : angle_sum;
      if (ki != 0 && mag > (longint'(1) <<< 60) / ki) ki_term = longint'(1) <<< 60;
      else ki_term = ki * mag;
      if (angle_sum < 0) ki_term = -ki_term;
      sum = longint'(servo_cfg.pos_kp) * err + ki_term
          + longint'(servo_cfg.pos_kd) * (err - angle_err_prev);
      angle_err_prev = err;
      sref = clamp_sym(sum >>> 8, longint'(servo_cfg.pos_limit));
    end
    // incremental speed loop
    err = sref - longint'(t.speed_fdb);
    sum = longint'(servo_cfg.spd_kp) * (err - spd_err_prev)
        + longint'(servo_cfg.spd_ki) * err
        + longint'(servo_cfg.spd_kd) * (err - 2 * spd_err_prev + spd_err_prev2);
    spd_err_prev2 = spd_err_prev;
    spd_err_prev  = err;
    drive_acc = clamp_sym(drive_acc + (sum >>> 8), longint'(servo_cfg.spd_limit));
    r.drive     = drive_acc[31:0];
    r.speed_ref = sref[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus monitor: tracks register writes, predicts on each slave transaction and
  // checks each master transaction. Everything is sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : bus_monitor
    tick_t      acc;
    servo_out_t got;
    servo_out_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        apply_reg(cfg_idx_i, cfg_wdata_i);
        reg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        acc.func      = s_axis_tuser;
        acc.target    = s_axis_tdata[31:0];
        acc.angle_fdb = s_axis_tdata[63:32];
        acc.speed_fdb = s_axis_tdata[95:64];
        expected_servo_q.push_back(servo_tick(acc));
        if (acc.func == MODE_POSITION) position_ticks++;
        else speed_ticks++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.drive     = m_axis_tdata[31:0];
        got.speed_ref = m_axis_tdata[63:32];
        if (expected_servo_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual drive %h speed_ref %h",
                   $time, got.drive, got.speed_ref);
        end else begin
          want = expected_servo_q.pop_front();
          results_checked++;
          if (got.drive !== want.drive) begin
            errors++;
            $display("%0t: drive mismatch: expected %h actual %h",
                     $time, want.drive, got.drive);
          end
          if (got.speed_ref !== want.speed_ref) begin
            errors++;
            $display("%0t: speed_ref mismatch: expected %h actual %h",
                     $time, want.speed_ref, got.speed_ref);
          end
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a solid hold-off while hold_cycles runs down.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver helpers. All of them start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one tick, with random idle cycles first; tvalid stays high on return
  // so back-to-back ticks need no extra cycle.
  task automatic send_tick(input bit func, input int target, input int angle,
                           input int speed);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {speed, angle, target};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_servo_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [cpsp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cpsp_pkg::LIMIT_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  // Write all eight registers; gains carry random junk above bit 15.
  task automatic program_regs(input cpsp_pkg::cfg_t c);
    write_reg(cpsp_pkg::CFG_POS_KP,    {15'($urandom), c.pos_kp});
    write_reg(cpsp_pkg::CFG_POS_KI,    {15'($urandom), c.pos_ki});
    write_reg(cpsp_pkg::CFG_POS_KD,    {15'($urandom), c.pos_kd});
    write_reg(cpsp_pkg::CFG_POS_LIMIT, c.pos_limit);
    write_reg(cpsp_pkg::CFG_SPD_KP,    {15'($urandom), c.spd_kp});
    write_reg(cpsp_pkg::CFG_SPD_KI,    {15'($urandom), c.spd_ki});
    write_reg(cpsp_pkg::CFG_SPD_KD,    {15'($urandom), c.spd_kd});
    write_reg(cpsp_pkg::CFG_SPD_LIMIT, c.spd_limit);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [cpsp_pkg::GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(0, 16'h0200));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [cpsp_pkg::LIMIT_W-1:0] random_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2, 3:    return 31'($urandom_range(0, 32'h00FF_FFFF));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic cpsp_pkg::cfg_t random_settings();
    cpsp_pkg::cfg_t c;
    c.pos_kp    = random_gain();
    c.pos_ki    = random_gain();
    c.pos_kd    = random_gain();
    c.pos_limit = random_limit();
    c.spd_kp    = random_gain();
    c.spd_ki    = random_gain();
    c.spd_kd    = random_gain();
    c.spd_limit = random_limit();
    return c;
  endfunction

  // mostly small Q16.16 values so the loops leave their clamps, plus extremes
  function automatic int random_sample();
    case ($urandom_range(0, 3))
      0: return int'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  task automatic send_random_tick();
    send_tick(1'($urandom_range(0, 1)), random_sample(), random_sample(),
              random_sample());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at reset: drive stays 0, position mode clamps speed_ref to 0.
  task automatic test_zero_gains();
    send_tick(MODE_SPEED,    Q_MAX, Q_MIN, Q_MIN);
    send_tick(MODE_POSITION, Q_MIN, Q_MAX, Q_MAX);
    send_tick(MODE_POSITION, Q_MAX, Q_MIN, 0);
    send_tick(MODE_SPEED,    -1,    0,     Q_MAX);
  endtask

  // Speed loop alone at unit-ish gains, full-range errors hitting both clamps.
  task automatic test_speed_directed();
    cpsp_pkg::cfg_t c;
    wait_idle();
    c = '{pos_kp: 16'h0001, pos_ki: 16'h0002, pos_kd: 16'h0003,
          pos_limit: 31'h0001_0000, spd_kp: 16'h0100, spd_ki: 16'h0080,
          spd_kd: 16'h0040, spd_limit: 31'h7FFF_FFFF};
    program_regs(c);
    send_tick(MODE_SPEED, Q_MAX, 0,     Q_MIN);
    send_tick(MODE_SPEED, Q_MIN, Q_MAX, Q_MAX);
    send_tick(MODE_SPEED, 0,     Q_MIN, 0);
    send_tick(MODE_SPEED, 1,     -1,    0);
    send_tick(MODE_SPEED, -1,    1,     0);
    send_tick(MODE_SPEED, 0,     0,     -1);
    send_tick(MODE_SPEED, Q_MAX, Q_MAX, Q_MAX);
    send_tick(MODE_SPEED, Q_MIN, Q_MIN, Q_MIN);
    send_tick(MODE_SPEED, 32'sh0001_0000, 0, 32'sh0000_8000);
  endtask

  // Position loop at full gains, derivative swings and mode switches that keep
  // all loop state.
  task automatic test_position_directed();
    cpsp_pkg::cfg_t c;
    wait_idle();
    c = '{pos_kp: 16'hFFFF, pos_ki: 16'hFFFF, pos_kd: 16'hFFFF,
          pos_limit: 31'h7FFF_FFFF, spd_kp: 16'hFFFF, spd_ki: 16'h0000,
          spd_kd: 16'hFFFF, spd_limit: 31'h0005_0000};
    program_regs(c);
    send_tick(MODE_POSITION, Q_MAX, Q_MIN, 0);
    send_tick(MODE_POSITION, Q_MIN, Q_MAX, Q_MAX);
    send_tick(MODE_POSITION, 0,     0,     Q_MIN);
    send_tick(MODE_POSITION, Q_MAX, Q_MAX, -1);
    send_tick(MODE_SPEED,    32'sh0001_0000, Q_MIN, 0);
    send_tick(MODE_POSITION, 32'sh0000_0100, 0, 0);
    send_tick(MODE_POSITION, -256,  0,     0);
    send_tick(MODE_SPEED,    Q_MIN, Q_MAX, Q_MAX);
    send_tick(MODE_POSITION, 1,     -1,    1);
    send_tick(MODE_POSITION, -1,    1,     -1);
  endtask

  // Drive the position integral into its positive rail, across to the negative
  // rail and back off it. With ki = 1 and the widest limit the integral shows
  // up directly in speed_ref, so a missing or wrong saturation is visible.
  task automatic test_integral_windup();
    cpsp_pkg::cfg_t c;
    wait_idle();
    c           = random_settings();
    c.pos_kp    = 16'($urandom_range(0, 3));
    c.pos_ki    = 16'h0001;
    c.pos_kd    = 16'($urandom_range(0, 3));
    c.pos_limit = 31'h7FFF_FFFF;
    program_regs(c);
    repeat (290) send_tick(MODE_POSITION, {16'h7FFF, 16'($urandom)},
                           {16'h8000, 16'($urandom)}, random_sample());
    repeat (290) send_tick(MODE_POSITION, {16'h8000, 16'($urandom)},
                           {16'h7FFF, 16'($urandom)}, random_sample());
    repeat (30)  send_tick(MODE_POSITION, {16'h7FFF, 16'($urandom)},
                           {16'h8000, 16'($urandom)}, random_sample());
  endtask

  // Random gains and limits, random ticks in both modes.
  task automatic test_random_servo(input int n_settings, input int n_ticks);
    repeat (n_settings) begin
      wait_idle();
      program_regs(random_settings());
      repeat (n_ticks) send_random_tick();
    end
  endtask

  // Receiver holds off while ticks keep coming: the output register and the
  // last sequencer step fill up and s_axis_tready must drop.
  task automatic test_backpressure();
    wait_idle();
    program_regs(random_settings());
    @(posedge clk_i);
    hold_cycles = HOLD_LEN;
    @(negedge clk_i);
    repeat (24) send_random_tick();
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles 37%, receiver 82%
    test_zero_gains();
    test_speed_directed();
    test_position_directed();
    test_random_servo(2, 110);

    // sender idles 82%, receiver 37%
    src_idle_pct = 82;
    snk_idle_pct = 37;
    test_integral_windup();
    test_random_servo(1, 110);

    // full rate on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_servo(1, 110);
    test_backpressure();

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Ran %0d speed-mode and %0d position-mode ticks over %0d register settings",
             speed_ticks, position_ticks, settings_count);
    $display("(%0d register writes); %0d results checked, %0d mismatches.",
             reg_writes, results_checked, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
